>>> rtl/core/tars_pkg.sv
// tars_pkg: shared types, codes and sizes of the two-axis ratio step generator
// depends on nothing; imported by every module of the block
package tars_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W   = $clog2(COORD_W + 1);
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] FN_MOVE  = 2'd0;
  localparam logic [1:0] FN_TICK  = 2'd1;
  localparam logic [1:0] FN_HOME  = 2'd2;
  localparam logic [1:0] LIM_CLR  = 2'd0;
  localparam logic [1:0] LIM_HOME = 2'd1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_HOME = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_RUN = 1'b0,
    BK_DIV = 1'b1
  } back_st_t;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic                      pen_raise;
    logic [1:0]                limit_x;
    logic [1:0]                limit_y;
  } tars_in_t;

  typedef struct packed {
    logic                      step_x;
    logic                      back_x;
    logic                      step_y;
    logic                      back_y;
    logic                      pen_is_up;
    logic signed [COORD_W-1:0] pos_x_out;
    logic signed [COORD_W-1:0] pos_y_out;
    logic [1:0]                mode_out;
  } tars_out_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic               pen_raise;
    logic               lim_any;
    logic               home_x;
    logic               home_y;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/two_axis_ratio_step_generator.sv
// two_axis_ratio_step_generator: top level of the plotter step generator
// depends on tars_pkg, tars_front, tars_fifo, tars_div, tars_back
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   input   | in_valid in_ready in_data      | one request: command + switches
//   output  | out_valid out_ready out_data   | one result per request
//
// a tick, home or dropped command is settled by the back end as it leaves the queue
// a move with both counts nonzero first runs the ratio divider, which gives
// one quotient bit per cycle; the back end holds off the queue meanwhile
// synchronous active-low reset; no clearing pass, ready the cycle after reset
// the two-entry queue keeps taking requests until full while a result waits on out_ready
module two_axis_ratio_step_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tars_pkg::tars_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tars_pkg::tars_out_t out_data
);
  import tars_pkg::*;

  q_stat_t   q_stat;
  q_entry_t  push_data, head;
  logic      push, pop;
  div_req_t  div_req;
  div_stat_t div_stat;
  logic [COORD_W-1:0] div_quot;

  tars_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tars_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  tars_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  tars_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .div_req   (div_req),
    .div_stat  (div_stat),
    .div_quot  (div_quot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue bookkeeping stays consistent
  a_q_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // no request leaves the queue while the ratio is being computed
  a_no_pop_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !pop)
    else $error("request popped during division");

  // a division result only follows a division in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> $past(div_stat.busy))
    else $error("divider done without running");

  // a pending result blocks the back end from consuming the next request
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !pop)
    else $error("request popped while result stalled");

endmodule

>>> rtl/core/tars_front.sv
// tars_front: accepts requests and classifies them into queue entries
// depends on tars_pkg
module tars_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  tars_pkg::tars_in_t in_data,
  input  tars_pkg::q_stat_t q_stat,
  output logic              push,
  output tars_pkg::q_entry_t push_data
);
  import tars_pkg::*;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    unique case (in_data.func)
      FN_MOVE: push_data.cmd = CMD_MOVE;
      FN_TICK: push_data.cmd = CMD_TICK;
      FN_HOME: push_data.cmd = CMD_HOME;
      default: push_data.cmd = CMD_NOP;
    endcase
    push_data.target_x  = in_data.target_x;
    push_data.target_y  = in_data.target_y;
    push_data.pen_raise = in_data.pen_raise;
    push_data.lim_any   = (in_data.limit_x != LIM_CLR) || (in_data.limit_y != LIM_CLR);
    push_data.home_x    = in_data.limit_x == LIM_HOME;
    push_data.home_y    = in_data.limit_y == LIM_HOME;
  end

endmodule

>>> rtl/core/tars_fifo.sv
// tars_fifo: short queue of classified requests between front and back
// depends on tars_pkg
module tars_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tars_pkg::q_entry_t push_data,
  input  logic               pop,
  output tars_pkg::q_entry_t head,
  output tars_pkg::q_stat_t  stat
);
  import tars_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

>>> rtl/core/tars_div.sv
// tars_div: restoring divider, one quotient bit per cycle
// depends on tars_pkg
module tars_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tars_pkg::div_req_t             req,
  output tars_pkg::div_stat_t            stat,
  output logic [tars_pkg::COORD_W-1:0]   quot
);
  import tars_pkg::*;

  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] quo_r, quo_nxt;
  logic [COORD_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [COORD_W:0]   rem_sh;
  logic [COORD_W:0]   diff;
  logic               ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[COORD_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = CNT_W'(COORD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
      quo_nxt = {quo_r[COORD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

>>> rtl/core/tars_back.sv
// tars_back: plotter state, move setup, stepping, homing and the result register
// depends on tars_pkg; drives tars_div through div_req_t
module tars_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tars_pkg::q_entry_t           head,
  input  tars_pkg::q_stat_t            q_stat,
  output logic                         pop,
  output tars_pkg::div_req_t           div_req,
  input  tars_pkg::div_stat_t          div_stat,
  input  logic [tars_pkg::COORD_W-1:0] div_quot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tars_pkg::tars_out_t          out_data
);
  import tars_pkg::*;

  back_st_t           st_r, st_nxt;
  mode_t              mode_r, mode_nxt;
  logic [COORD_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [COORD_W-1:0] left_x_r, left_x_nxt, left_y_r, left_y_nxt;
  logic [COORD_W-1:0] ratio_r, ratio_nxt, rc_r, rc_nxt;
  logic               dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic               x_leads_r, x_leads_nxt, pen_r, pen_nxt;
  logic               out_valid_r, out_valid_nxt;
  tars_out_t          out_r, out_nxt;

  logic               sx, sy;
  logic [COORD_W:0]   dx, dy, dx_abs, dy_abs;
  logic [COORD_W-1:0] ax, ay, big, sml;
  logic               y_lead;
  logic [COORD_W-1:0] lead, other, lead_n, other_n, rc_t;
  logic               lead_step, other_step, c2;

  always_comb begin
    dx     = {pos_x_r[COORD_W-1], pos_x_r} - {head.target_x[COORD_W-1], head.target_x};
    dy     = {pos_y_r[COORD_W-1], pos_y_r} - {head.target_y[COORD_W-1], head.target_y};
    dx_abs = dx[COORD_W] ? (~dx + 1'b1) : dx;
    dy_abs = dy[COORD_W] ? (~dy + 1'b1) : dy;
    ax     = dx_abs[COORD_W-1:0];
    ay     = dy_abs[COORD_W-1:0];
    y_lead = ay > ax;
    big    = y_lead ? ay : ax;
    sml    = y_lead ? ax : ay;

    lead       = x_leads_r ? left_x_r : left_y_r;
    other      = x_leads_r ? left_y_r : left_x_r;
    lead_step  = (lead != '0) && ((rc_r < ratio_r) || (other == '0));
    lead_n     = lead - COORD_W'(lead_step);
    rc_t       = rc_r + COORD_W'(lead_step);
    c2         = ((other != '0) && (rc_t >= ratio_r)) || (lead_n == '0);
    other_step = c2 && (other != '0);
    other_n    = other - COORD_W'(other_step);
    if (c2) begin
      rc_t = '0;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    mode_nxt    = mode_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    left_x_nxt  = left_x_r;
    left_y_nxt  = left_y_r;
    ratio_nxt   = ratio_r;
    rc_nxt      = rc_r;
    dir_x_nxt   = dir_x_r;
    dir_y_nxt   = dir_y_r;
    x_leads_nxt = x_leads_r;
    pen_nxt     = pen_r;
    sx          = 1'b0;
    sy          = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = big;
    div_req.den   = sml;
    pop         = 1'b0;

    unique case (st_r)
      BK_DIV: begin
        if (div_stat.done) begin
          ratio_nxt = div_quot;
          st_nxt    = BK_RUN;
        end
      end
      BK_RUN: begin
        pop = !q_stat.empty && (!out_valid_r || out_ready);
        if (pop) begin
          unique case (head.cmd)
            CMD_MOVE: begin
              if (mode_r == MODE_IDLE && (dx != '0 || dy != '0)) begin
                dir_x_nxt   = dx[COORD_W];
                dir_y_nxt   = dy[COORD_W];
                x_leads_nxt = !y_lead;
                left_x_nxt  = ax;
                left_y_nxt  = ay;
                rc_nxt      = '0;
                pen_nxt     = head.pen_raise;
                mode_nxt    = MODE_MOVE;
                if (sml == '0) begin
                  ratio_nxt = '0;
                end else begin
                  div_req.start = 1'b1;
                  st_nxt        = BK_DIV;
                end
              end
            end
            CMD_HOME: begin
              if (mode_r == MODE_IDLE) begin
                left_x_nxt = '0;
                left_y_nxt = '0;
                rc_nxt     = '0;
                pen_nxt    = 1'b1;
                dir_x_nxt  = 1'b1;
                dir_y_nxt  = 1'b1;
                mode_nxt   = MODE_HOME;
              end
            end
            CMD_TICK: begin
              if (mode_r == MODE_MOVE) begin
                sx         = x_leads_r ? lead_step : other_step;
                sy         = x_leads_r ? other_step : lead_step;
                left_x_nxt = x_leads_r ? lead_n : other_n;
                left_y_nxt = x_leads_r ? other_n : lead_n;
                rc_nxt     = rc_t;
                if (sx) begin
                  pos_x_nxt = dir_x_r ? pos_x_r + 1'b1 : pos_x_r - 1'b1;
                end
                if (sy) begin
                  pos_y_nxt = dir_y_r ? pos_y_r + 1'b1 : pos_y_r - 1'b1;
                end
                if (head.lim_any) begin
                  left_x_nxt = '0;
                  left_y_nxt = '0;
                  rc_nxt     = '0;
                  pen_nxt    = 1'b1;
                  dir_x_nxt  = 1'b1;
                  dir_y_nxt  = 1'b1;
                  mode_nxt   = MODE_HOME;
                end else if (left_x_nxt == '0 && left_y_nxt == '0) begin
                  mode_nxt = MODE_IDLE;
                end
              end else if (mode_r == MODE_HOME) begin
                if (head.home_x && head.home_y) begin
                  pos_x_nxt = '0;
                  pos_y_nxt = '0;
                  mode_nxt  = MODE_IDLE;
                end else begin
                  if (!head.home_x) begin
                    sx        = 1'b1;
                    pos_x_nxt = pos_x_r - 1'b1;
                  end
                  if (!head.home_y) begin
                    sy        = 1'b1;
                    pos_y_nxt = pos_y_r - 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: st_nxt = BK_RUN;
    endcase

    out_nxt.step_x    = sx;
    out_nxt.back_x    = dir_x_nxt;
    out_nxt.step_y    = sy;
    out_nxt.back_y    = dir_y_nxt;
    out_nxt.pen_is_up = pen_nxt;
    out_nxt.pos_x_out = pos_x_nxt;
    out_nxt.pos_y_out = pos_y_nxt;
    out_nxt.mode_out  = mode_nxt;
    out_valid_nxt     = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_RUN;
      mode_r      <= MODE_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      left_x_r    <= '0;
      left_y_r    <= '0;
      ratio_r     <= '0;
      rc_r        <= '0;
      dir_x_r     <= 1'b0;
      dir_y_r     <= 1'b0;
      x_leads_r   <= 1'b1;
      pen_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      left_x_r    <= left_x_nxt;
      left_y_r    <= left_y_nxt;
      ratio_r     <= ratio_nxt;
      rc_r        <= rc_nxt;
      dir_x_r     <= dir_x_nxt;
      dir_y_r     <= dir_y_nxt;
      x_leads_r   <= x_leads_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
